>>> rtl/core/dst5_pkg.sv
// Shared types and fixed widths for the five-axis range and Jacobian block.
package dst5_pkg;

	localparam int IN_W    = 48;
	localparam int RANGE_W = 50;
	localparam int GRAD_W  = 32;
	localparam int N_AX    = 5;

	typedef struct packed {
		logic signed [IN_W-1:0] p_x;
		logic signed [IN_W-1:0] p_y;
		logic signed [IN_W-1:0] p_z;
		logic signed [IN_W-1:0] p_clock_bias;
		logic signed [IN_W-1:0] p_tropo;
		logic signed [IN_W-1:0] q_x;
		logic signed [IN_W-1:0] q_y;
		logic signed [IN_W-1:0] q_z;
		logic signed [IN_W-1:0] q_clock_bias;
		logic signed [IN_W-1:0] q_tropo;
	} operands_t;

	typedef struct packed {
		logic [RANGE_W-1:0]       range;
		logic signed [GRAD_W-1:0] grad_p_x;
		logic signed [GRAD_W-1:0] grad_p_y;
		logic signed [GRAD_W-1:0] grad_p_z;
		logic signed [GRAD_W-1:0] grad_p_clock_bias;
		logic signed [GRAD_W-1:0] grad_p_tropo;
		logic signed [GRAD_W-1:0] grad_q_x;
		logic signed [GRAD_W-1:0] grad_q_y;
		logic signed [GRAD_W-1:0] grad_q_z;
		logic signed [GRAD_W-1:0] grad_q_clock_bias;
		logic signed [GRAD_W-1:0] grad_q_tropo;
		logic                     zero_range;
	} result_t;

endpackage

>>> rtl/core/distance5_with_jacobian.sv
// Top level: five-axis Euclidean range with Jacobians, fully pipelined.
// Pipeline: four arithmetic stages, one square root cell per root bit, one divider cell
// per quotient bit, and the output register; RW = COORD_WIDTH + 3 root bits.
// Throughput: one word per cycle; busy is held low, results appear on done for one cycle.
// Reset clears every stage valid bit; datapath registers are not reset.
module distance5_with_jacobian import dst5_pkg::*; #(
	parameter int COORD_WIDTH    = 48,
	parameter int GRAD_FRAC_BITS = 30
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  operands_t operands,
	output logic      done,
	output result_t   result
);

	// widths derived from the coordinate width
	localparam int MAG_W  = COORD_WIDTH + 1;          // |p - q|
	localparam int LO_W   = (MAG_W + 1) / 2;          // square split
	localparam int HI_W   = MAG_W - LO_W;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int SUM_W  = SQ_W + 3;                 // sum of five squares
	localparam int RW     = (SUM_W + 1) / 2;          // root width
	localparam int QW     = GRAD_FRAC_BITS + 1;       // quotient reaches 2^F
	localparam int SIDE_W = N_AX * MAG_W + N_AX;
	localparam int RX_W   = (RW > RANGE_W) ? RW : RANGE_W;
	localparam int GX_W   = (QW > GRAD_W) ? QW : GRAD_W;
	localparam int LAT    = 5 + RW + QW;

	localparam logic [RX_W-1:0] RANGE_MAX = RX_W'({RANGE_W{1'b1}});
	localparam logic [GX_W-1:0] GRAD_MAX  = GX_W'({(GRAD_W-1){1'b1}});

	assign busy = 1'b0;     // every stage advances each cycle

	function automatic logic signed [COORD_WIDTH-1:0] coord(input logic signed [IN_W-1:0] f);
		logic signed [63:0] w;
		w = 64'(f);
		return w[COORD_WIDTH-1:0];
	endfunction

	logic signed [IN_W-1:0] p_in [N_AX];
	logic signed [IN_W-1:0] q_in [N_AX];

	assign p_in[0] = operands.p_x;
	assign p_in[1] = operands.p_y;
	assign p_in[2] = operands.p_z;
	assign p_in[3] = operands.p_clock_bias;
	assign p_in[4] = operands.p_tropo;
	assign q_in[0] = operands.q_x;
	assign q_in[1] = operands.q_y;
	assign q_in[2] = operands.q_z;
	assign q_in[3] = operands.q_clock_bias;
	assign q_in[4] = operands.q_tropo;

	// ---- s1: per-axis difference, sign and magnitude
	logic signed [COORD_WIDTH:0] diff [N_AX];
	logic [MAG_W-1:0]            mag_n [N_AX];
	logic [N_AX-1:0]             neg_n;

	always_comb begin
		for (int i = 0; i < N_AX; i++) begin
			logic signed [COORD_WIDTH-1:0] pc;
			logic signed [COORD_WIDTH-1:0] qc;
			pc       = coord(p_in[i]);
			qc       = coord(q_in[i]);
			diff[i]  = {pc[COORD_WIDTH-1], pc} - {qc[COORD_WIDTH-1], qc};
			neg_n[i] = diff[i][COORD_WIDTH];
			mag_n[i] = neg_n[i] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
		end
	end

	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	logic [MAG_W-1:0] mag_s1 [N_AX];
	logic [N_AX-1:0]  neg_s1;

	// ---- s2: partial products of each square
	logic [MAG_W-1:0]     mag_s2 [N_AX];
	logic [N_AX-1:0]      neg_s2;
	logic [2*HI_W-1:0]    hh_s2  [N_AX];
	logic [HI_W+LO_W-1:0] hl_s2  [N_AX];
	logic [2*LO_W-1:0]    ll_s2  [N_AX];

	// ---- s3: per-axis squares; s4: their sum
	logic [MAG_W-1:0] mag_s3 [N_AX];
	logic [N_AX-1:0]  neg_s3;
	logic [SQ_W-1:0]  sq_s3  [N_AX];
	logic [MAG_W-1:0] mag_s4 [N_AX];
	logic [N_AX-1:0]  neg_s4;
	logic [SUM_W-1:0] sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		logic [SUM_W-1:0] acc;
		neg_s1 <= neg_n;
		neg_s2 <= neg_s1;
		neg_s3 <= neg_s2;
		neg_s4 <= neg_s3;
		acc = '0;
		for (int i = 0; i < N_AX; i++) begin
			mag_s1[i] <= mag_n[i];
			mag_s2[i] <= mag_s1[i];
			hh_s2[i]  <= mag_s1[i][MAG_W-1:LO_W] * mag_s1[i][MAG_W-1:LO_W];
			hl_s2[i]  <= mag_s1[i][MAG_W-1:LO_W] * mag_s1[i][LO_W-1:0];
			ll_s2[i]  <= mag_s1[i][LO_W-1:0] * mag_s1[i][LO_W-1:0];
			mag_s3[i] <= mag_s2[i];
			sq_s3[i]  <= (SQ_W'(hh_s2[i]) << (2 * LO_W)) + (SQ_W'(hl_s2[i]) << (LO_W + 1))
				+ SQ_W'(ll_s2[i]);
			mag_s4[i] <= mag_s3[i];
			acc = acc + SUM_W'(sq_s3[i]);
		end
		sum_s4 <= acc;
	end

	// ---- square root chain, one root bit per cell
	logic              sq_vld  [RW+1];
	logic [2*RW-1:0]   sq_rad  [RW+1];
	logic [RW:0]       sq_rem  [RW+1];
	logic [RW-1:0]     sq_root [RW+1];
	logic [SIDE_W-1:0] sq_side [RW+1];
	logic [SIDE_W-1:0] side_s4;

	always_comb begin
		side_s4[N_AX-1:0] = neg_s4;
		for (int i = 0; i < N_AX; i++) begin
			side_s4[N_AX + i*MAG_W +: MAG_W] = mag_s4[i];
		end
	end

	assign sq_vld[0]  = vld_s4;
	assign sq_rad[0]  = (2*RW)'(sum_s4);
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = side_s4;

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		dst5_sqrt_cell #(.RW(RW), .SIDE_W(SIDE_W)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (sq_vld[k]),
			.rad_i  (sq_rad[k]),
			.rem_i  (sq_rem[k]),
			.root_i (sq_root[k]),
			.side_i (sq_side[k]),
			.vld_o  (sq_vld[k+1]),
			.rad_o  (sq_rad[k+1]),
			.rem_o  (sq_rem[k+1]),
			.root_o (sq_root[k+1]),
			.side_o (sq_side[k+1])
		);
	end

	// ---- divider chain: (mag << F) / range, one quotient bit per cell.
	// mag never exceeds range, so the chain starts at mag >> 1 with mag[0] fed in.
	logic            dv_vld [QW+1];
	logic [RW-1:0]   dv_den [QW+1];
	logic [N_AX-1:0] dv_neg [QW+1];
	logic [N_AX-1:0] dv_bit [QW];
	logic [RW-1:0]   dv_rem [QW+1][N_AX];
	logic [QW-1:0]   dv_quo [QW+1][N_AX];

	assign dv_vld[0] = sq_vld[RW];
	assign dv_den[0] = sq_root[RW];
	assign dv_neg[0] = sq_side[RW][N_AX-1:0];

	for (genvar i = 0; i < N_AX; i++) begin : g_lane
		logic [MAG_W-1:0] m;
		assign m            = sq_side[RW][N_AX + i*MAG_W +: MAG_W];
		assign dv_rem[0][i] = RW'(m >> 1);
		assign dv_quo[0][i] = '0;
		assign dv_bit[0][i] = m[0];
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		if (k > 0) begin : g_zero
			assign dv_bit[k] = '0;
		end
		dst5_div_cell #(.RW(RW), .QW(QW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (dv_vld[k]),
			.den_i  (dv_den[k]),
			.bit_i  (dv_bit[k]),
			.neg_i  (dv_neg[k]),
			.rem_i  (dv_rem[k]),
			.quo_i  (dv_quo[k]),
			.vld_o  (dv_vld[k+1]),
			.den_o  (dv_den[k+1]),
			.neg_o  (dv_neg[k+1]),
			.rem_o  (dv_rem[k+1]),
			.quo_o  (dv_quo[k+1])
		);
	end

	// ---- output register: saturate, apply signs, zero-range override
	logic [RX_W-1:0]          rng_x;
	logic                     zero;
	logic signed [GRAD_W-1:0] gp [N_AX];
	logic signed [GRAD_W-1:0] gq [N_AX];

	always_comb begin
		rng_x = RX_W'(dv_den[QW]);
		if (rng_x > RANGE_MAX) begin
			rng_x = RANGE_MAX;
		end
		zero = dv_den[QW] == '0;
		for (int i = 0; i < N_AX; i++) begin
			logic [GX_W-1:0] g;
			g = GX_W'(dv_quo[QW][i]);
			if (g > GRAD_MAX) begin
				g = GRAD_MAX;
			end
			if (zero) begin
				g = '0;
			end
			gp[i] = dv_neg[QW][i] ? -GRAD_W'(g) : GRAD_W'(g);
			gq[i] = -gp[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_vld[QW];
		end
	end

	always_ff @(posedge clk) begin
		result.range             <= rng_x[RANGE_W-1:0];
		result.grad_p_x          <= gp[0];
		result.grad_p_y          <= gp[1];
		result.grad_p_z          <= gp[2];
		result.grad_p_clock_bias <= gp[3];
		result.grad_p_tropo      <= gp[4];
		result.grad_q_x          <= gq[0];
		result.grad_q_y          <= gq[1];
		result.grad_q_z          <= gq[2];
		result.grad_q_clock_bias <= gq[3];
		result.grad_q_tropo      <= gq[4];
		result.zero_range        <= zero;
	end

	// ---- checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result word missing at pipeline latency");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.zero_range == (result.range == '0)))
		else $error("zero_range disagrees with range");

	a_zero_grad: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.zero_range |-> result.grad_p_x == '0 && result.grad_q_tropo == '0)
		else $error("gradient not cleared on zero range");

	a_negation: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.grad_q_y == -result.grad_p_y && result.grad_q_z == -result.grad_p_z)
		else $error("q-Jacobian is not the negated p-Jacobian");

endmodule

>>> rtl/core/dst5_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per word.
module dst5_sqrt_cell import dst5_pkg::*; #(
	parameter int RW     = 51,
	parameter int SIDE_W = 250
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_i,
	input  logic [2*RW-1:0]   rad_i,
	input  logic [RW:0]       rem_i,
	input  logic [RW-1:0]     root_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic              vld_o,
	output logic [2*RW-1:0]   rad_o,
	output logic [RW:0]       rem_o,
	output logic [RW-1:0]     root_o,
	output logic [SIDE_W-1:0] side_o
);

	logic [RW+1:0] rem_sh;
	logic [RW+1:0] trial;
	logic          ge;
	logic [RW+1:0] rem_n;

	always_comb begin
		rem_sh = {rem_i[RW-1:0], rad_i[2*RW-1 -: 2]};
		trial  = {root_i, 2'b01};
		ge     = rem_sh >= trial;
		rem_n  = ge ? rem_sh - trial : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		rad_o  <= {rad_i[2*RW-3:0], 2'b00};
		rem_o  <= rem_n[RW:0];
		root_o <= {root_i[RW-2:0], ge};
		side_o <= side_i;
	end

endmodule

>>> rtl/core/dst5_div_cell.sv
// One cell of the divider chain: one quotient bit for each of the five axes.
module dst5_div_cell import dst5_pkg::*; #(
	parameter int RW = 51,
	parameter int QW = 31
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_i,
	input  logic [RW-1:0]     den_i,
	input  logic [N_AX-1:0]   bit_i,
	input  logic [N_AX-1:0]   neg_i,
	input  logic [RW-1:0]     rem_i [N_AX],
	input  logic [QW-1:0]     quo_i [N_AX],
	output logic              vld_o,
	output logic [RW-1:0]     den_o,
	output logic [N_AX-1:0]   neg_o,
	output logic [RW-1:0]     rem_o [N_AX],
	output logic [QW-1:0]     quo_o [N_AX]
);

	logic [RW:0]     rem_sh [N_AX];
	logic [RW:0]     rem_n  [N_AX];
	logic [N_AX-1:0] ge;

	always_comb begin
		for (int i = 0; i < N_AX; i++) begin
			rem_sh[i] = {rem_i[i], bit_i[i]};
			ge[i]     = rem_sh[i] >= {1'b0, den_i};
			rem_n[i]  = ge[i] ? rem_sh[i] - {1'b0, den_i} : rem_sh[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		den_o <= den_i;
		neg_o <= neg_i;
		for (int i = 0; i < N_AX; i++) begin
			rem_o[i] <= rem_n[i][RW-1:0];
			quo_o[i] <= {quo_i[i][QW-2:0], ge[i]};
		end
	end

endmodule

>>> tb/sv/tb_distance5_with_jacobian.sv
// Self-checking testbench for the five-axis range and Jacobian block.
module tb_distance5_with_jacobian;
	import dst5_pkg::*;

	localparam int FRAC   = 30;   // gradient fraction bits at the default build
	localparam int LAT    = 87;   // pipeline depth of the top level at the default build
	localparam logic signed [IN_W-1:0] C_MAX = {1'b0, {(IN_W-1){1'b1}}};
	localparam logic signed [IN_W-1:0] C_MIN = {1'b1, {(IN_W-1){1'b0}}};

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	operands_t operands;
	logic      done;
	result_t   result;

	result_t   expected_q[$];   // expected words, oldest first
	int        fails;
	int        idle_pct;        // chance of the sender idling in any one cycle

	distance5_with_jacobian dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operands(operands), .done(done), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous ceiling on the whole run
	initial begin
		#20000000;
		$display("distance5_with_jacobian regression: fail");
		$finish;
	end

	// floor(sqrt(s)); s stays below 2^99
	function automatic logic [63:0] isqrt(logic [127:0] s);
		logic [63:0]  r;
		logic [63:0]  c;
		logic [127:0] sq;
		r = '0;
		for (int b = 62; b >= 0; b--) begin
			c = r | (64'd1 << b);
			sq = {64'd0, c} * {64'd0, c};
			if (sq <= s)
				r = c;
		end
		return r;
	endfunction

	// range and both Jacobians for one operand word
	function automatic result_t predict_range_grad(operands_t op);
		logic signed [IN_W-1:0] pv[N_AX];
		logic signed [IN_W-1:0] qv[N_AX];
		logic signed [IN_W:0]   d[N_AX];
		logic [IN_W:0]          mag[N_AX];
		logic [127:0]           acc;
		logic [63:0]            rng;
		logic [127:0]           g;
		logic [GRAD_W-1:0]      gp[N_AX];
		logic [GRAD_W-1:0]      gq[N_AX];
		result_t                r;
		pv = '{op.p_x, op.p_y, op.p_z, op.p_clock_bias, op.p_tropo};
		qv = '{op.q_x, op.q_y, op.q_z, op.q_clock_bias, op.q_tropo};
		acc = '0;
		for (int i = 0; i < N_AX; i++) begin
			d[i]   = {pv[i][IN_W-1], pv[i]} - {qv[i][IN_W-1], qv[i]};
			mag[i] = d[i][IN_W] ? -d[i] : d[i];
			acc    = acc + {79'd0, mag[i]} * {79'd0, mag[i]};
		end
		rng = isqrt(acc);
		for (int i = 0; i < N_AX; i++) begin
			g = '0;
			if (rng != 0) begin
				g = ({79'd0, mag[i]} << FRAC) / {64'd0, rng};
				if (g > 128'h7FFF_FFFF)
					g = 128'h7FFF_FFFF;
			end
			if (d[i][IN_W]) begin
				gp[i] = -g[GRAD_W-1:0];
				gq[i] = g[GRAD_W-1:0];
			end else begin
				gp[i] = g[GRAD_W-1:0];
				gq[i] = -g[GRAD_W-1:0];
			end
		end
		r.range = (rng > {14'd0, {RANGE_W{1'b1}}}) ? {RANGE_W{1'b1}} : rng[RANGE_W-1:0];
		r.grad_p_x = gp[0]; r.grad_p_y = gp[1]; r.grad_p_z = gp[2];
		r.grad_p_clock_bias = gp[3]; r.grad_p_tropo = gp[4];
		r.grad_q_x = gq[0]; r.grad_q_y = gq[1]; r.grad_q_z = gq[2];
		r.grad_q_clock_bias = gq[3]; r.grad_q_tropo = gq[4];
		r.zero_range = (rng == 0);
		return r;
	endfunction

	// Result checker: done is sampled on the edge that accepts the word.
	always @(posedge clk) begin
		result_t e;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result word: %p", result);
				fails++;
			end else begin
				e = expected_q.pop_front();
				if (result.range !== e.range) begin
					$error("range: expected %0d, got %0d", e.range, result.range);
					fails++;
				end
				if (result.grad_p_x !== e.grad_p_x) begin
					$error("grad_p_x: expected %0d, got %0d", e.grad_p_x, result.grad_p_x);
					fails++;
				end
				if (result.grad_p_y !== e.grad_p_y) begin
					$error("grad_p_y: expected %0d, got %0d", e.grad_p_y, result.grad_p_y);
					fails++;
				end
				if (result.grad_p_z !== e.grad_p_z) begin
					$error("grad_p_z: expected %0d, got %0d", e.grad_p_z, result.grad_p_z);
					fails++;
				end
				if (result.grad_p_clock_bias !== e.grad_p_clock_bias) begin
					$error("grad_p_clock_bias: expected %0d, got %0d",
						e.grad_p_clock_bias, result.grad_p_clock_bias);
					fails++;
				end
				if (result.grad_p_tropo !== e.grad_p_tropo) begin
					$error("grad_p_tropo: expected %0d, got %0d",
						e.grad_p_tropo, result.grad_p_tropo);
					fails++;
				end
				if (result.grad_q_x !== e.grad_q_x) begin
					$error("grad_q_x: expected %0d, got %0d", e.grad_q_x, result.grad_q_x);
					fails++;
				end
				if (result.grad_q_y !== e.grad_q_y) begin
					$error("grad_q_y: expected %0d, got %0d", e.grad_q_y, result.grad_q_y);
					fails++;
				end
				if (result.grad_q_z !== e.grad_q_z) begin
					$error("grad_q_z: expected %0d, got %0d", e.grad_q_z, result.grad_q_z);
					fails++;
				end
				if (result.grad_q_clock_bias !== e.grad_q_clock_bias) begin
					$error("grad_q_clock_bias: expected %0d, got %0d",
						e.grad_q_clock_bias, result.grad_q_clock_bias);
					fails++;
				end
				if (result.grad_q_tropo !== e.grad_q_tropo) begin
					$error("grad_q_tropo: expected %0d, got %0d",
						e.grad_q_tropo, result.grad_q_tropo);
					fails++;
				end
				if (result.zero_range !== e.zero_range) begin
					$error("zero_range: expected %0b, got %0b", e.zero_range, result.zero_range);
					fails++;
				end
			end
		end
	end

	// Present one word; it is taken on the first edge with busy low.
	// start stays high into the next word unless a gap is drawn, so no
	// signal sees two nonblocking writes in one step.
	task automatic send_word(operands_t op);
		operands <= op;
		start    <= 1'b1;
		do @(posedge clk); while (busy);
		expected_q.push_back(predict_range_grad(op));
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
	endtask

	// lower start after the last word of a test
	task automatic park_sender();
		start <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [IN_W-1:0] rnd_coord();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(5))
			0: return C_MAX;
			1: return C_MIN;
			2: return $signed(v[15:0]) - 48'sd32768;   // near zero
			default: return v[IN_W-1:0];
		endcase
	endfunction

	function automatic operands_t make_pair(logic signed [IN_W-1:0] pv[N_AX],
			logic signed [IN_W-1:0] qv[N_AX]);
		operands_t op;
		op.p_x = pv[0]; op.p_y = pv[1]; op.p_z = pv[2];
		op.p_clock_bias = pv[3]; op.p_tropo = pv[4];
		op.q_x = qv[0]; op.q_y = qv[1]; op.q_z = qv[2];
		op.q_clock_bias = qv[3]; op.q_tropo = qv[4];
		return op;
	endfunction

	// extremes of every field, single-axis offsets (gradient of exactly one)
	task automatic test_extremes();
		logic signed [IN_W-1:0] pv[N_AX];
		logic signed [IN_W-1:0] qv[N_AX];
		idle_pct = 0;
		pv = '{default: C_MAX}; qv = '{default: C_MIN};
		send_word(make_pair(pv, qv));
		send_word(make_pair(qv, pv));
		pv = '{default: C_MIN}; qv = '{default: C_MIN};
		send_word(make_pair(pv, qv));
		pv = '{default: '1}; qv = '{default: '0};
		send_word(make_pair(pv, qv));
		send_word(make_pair(qv, pv));
		for (int a = 0; a < N_AX; a++) begin
			pv = '{default: '0}; qv = '{default: '0};
			pv[a] = C_MAX; qv[a] = C_MIN;
			send_word(make_pair(pv, qv));
			send_word(make_pair(qv, pv));
		end
		pv = '{48'sd1, 48'sd0, -48'sd1, 48'sd2, -48'sd3};
		qv = '{default: '0};
		send_word(make_pair(pv, qv));
		park_sender();
	endtask

	// p equal to q: flag up, all gradients zero
	task automatic test_zero_range();
		logic signed [IN_W-1:0] pv[N_AX];
		idle_pct = 0;
		pv = '{default: '0};
		send_word(make_pair(pv, pv));
		pv = '{default: C_MAX};
		send_word(make_pair(pv, pv));
		pv = '{C_MIN, C_MAX, '0, 48'sd5, -48'sd5};
		send_word(make_pair(pv, pv));
		park_sender();
	endtask

	task automatic test_random(int n, int pct);
		logic signed [IN_W-1:0] pv[N_AX];
		logic signed [IN_W-1:0] qv[N_AX];
		idle_pct = pct;
		for (int k = 0; k < n; k++) begin
			for (int a = 0; a < N_AX; a++) begin
				pv[a] = rnd_coord();
				case ($urandom_range(4))
					0: qv[a] = pv[a];                                   // shared axis
					1: qv[a] = pv[a] + ($signed({$urandom} % 64) - 32); // close by
					default: qv[a] = rnd_coord();
				endcase
			end
			if ($urandom_range(19) == 0)
				qv = pv;
			send_word(make_pair(pv, qv));
		end
		park_sender();
	endtask

	initial begin
		fails    = 0;
		idle_pct = 0;
		arst_n   = 1'b0;
		start    = 1'b0;
		operands = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_zero_range();
		test_random(300, 0);    // back to back
		test_random(300, 69);   // sender mostly idle
		test_random(250, 0);    // receiver side cannot stall; full rate again
		test_random(250, 33);   // mixed gaps

		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (LAT + 20) @(posedge clk);

		if (fails == 0)
			$display("distance5_with_jacobian regression: pass");
		else
			$display("distance5_with_jacobian regression: fail");
		$finish;
	end

endmodule
